// ===== rtl/emi2d_pkg.sv =====
// ----------------------------------------------------------------------------
// emi2d_pkg
// Shared types, constants and helpers for the 2D motion integrator.
// ----------------------------------------------------------------------------
package emi2d_pkg;

    // Fixed point format of position, velocity and acceleration
    localparam int FRAC_BITS  = 16;
    // Fraction bits of the slide ratio
    localparam int RATIO_BITS = 16;
    // 0.05 rounded to nearest at FRAC_BITS
    localparam int SLIDE_THRESH = ((5 << FRAC_BITS) + 50) / 100;

    localparam int VAL_W    = 32;
    localparam int STEP_W   = 17;
    localparam int RATIO_W  = 17;
    localparam int LIMIT_W  = 31;
    localparam int MODE_W   = 4;
    localparam int OPC_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: signed value times zero-extended step or ratio
    localparam int MUL_B_W = STEP_W + 1;
    localparam int PROD_W  = VAL_W + MUL_B_W;
    // Width used ahead of saturation
    localparam int SAT_W   = VAL_W + 8;

    // Stream word layout
    localparam int IN_FIELDS_W = STEP_W + 2 * VAL_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 4 * VAL_W;

    // mode_flags bits
    localparam int MODE_GRAVITY = 0;
    localparam int MODE_FOLLOW  = 1;
    localparam int MODE_LIMIT   = 2;
    localparam int MODE_SLIDE   = 3;

    typedef enum logic [OPC_W-1:0] {
        OP_TICK     = 2'd0,
        OP_LOAD_POS = 2'd1,
        OP_LOAD_VEL = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY_RATE = 3'd0,
        REG_FALL_LIMIT   = 3'd1,
        REG_SLIDE_RATIO  = 3'd2,
        REG_MODE_FLAGS   = 3'd3,
        REG_BOUND_LEFT   = 3'd4,
        REG_BOUND_RIGHT  = 3'd5,
        REG_BOUND_BOTTOM = 3'd6,
        REG_BOUND_TOP    = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        MUL_GRAV,
        MUL_VX_TS,
        MUL_VY_TS,
        MUL_VX_RATIO,
        MUL_VY_RATIO
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD_POS,
        ACT_LOAD_VEL,
        ACT_GRAV,
        ACT_FOLLOW,
        ACT_INT_X,
        ACT_INT_Y,
        ACT_CLAMP,
        ACT_SLIDE_X,
        ACT_SLIDE_Y,
        ACT_SLIDE_CHK
    } act_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        act_t     act;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              vel_zero;
    } dp_status_t;

    localparam logic signed [SAT_W-1:0] SAT_MAX = {{(SAT_W-VAL_W){1'b0}}, 1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_MIN = {{(SAT_W-VAL_W){1'b1}}, 1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[VAL_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[VAL_W-1:0];
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/emi2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// emi2d_ctrl
// Sequencer: walks one item through the datapath steps and owns the
// output word valid.
// ----------------------------------------------------------------------------
module emi2d_ctrl
    import emi2d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OPC_W-1:0] in_opcode,
    output logic             out_valid,
    input  logic             out_ready,
    input  dp_status_t       status,
    output dp_cmd_t          cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_POS,
        S_LOAD_VEL,
        S_GRAV_MUL,
        S_GRAV,
        S_FOLLOW,
        S_MUL_X,
        S_INT_X,
        S_INT_Y,
        S_CLAMP,
        S_SLIDE_X,
        S_SLIDE_Y,
        S_SLIDE_CHK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slide_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slide_go  = status.mode[MODE_SLIDE] && !status.vel_zero;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_GRAV;
        cmd.act        = ACT_NONE;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (opcode_t'(in_opcode))
                        OP_LOAD_POS: state_next = S_LOAD_POS;
                        OP_LOAD_VEL: state_next = S_LOAD_VEL;
                        OP_TICK:
                        begin
                            if (status.mode[MODE_GRAVITY])
                                state_next = S_GRAV_MUL;
                            else if (status.mode[MODE_FOLLOW])
                                state_next = S_FOLLOW;
                            else
                                state_next = S_MUL_X;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD_POS:
            begin
                cmd.act    = ACT_LOAD_POS;
                state_next = S_DONE;
            end
            S_LOAD_VEL:
            begin
                cmd.act    = ACT_LOAD_VEL;
                state_next = S_DONE;
            end
            S_GRAV_MUL:
            begin
                cmd.mul_sel = MUL_GRAV;
                state_next  = S_GRAV;
            end
            S_GRAV:
            begin
                cmd.act    = ACT_GRAV;
                state_next = status.mode[MODE_FOLLOW] ? S_FOLLOW : S_MUL_X;
            end
            S_FOLLOW:
            begin
                cmd.act    = ACT_FOLLOW;
                state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                cmd.mul_sel = MUL_VX_TS;
                state_next  = S_INT_X;
            end
            S_INT_X:
            begin
                cmd.act     = ACT_INT_X;
                cmd.mul_sel = MUL_VY_TS;
                state_next  = S_INT_Y;
            end
            S_INT_Y:
            begin
                cmd.act = ACT_INT_Y;
                if (status.mode[MODE_LIMIT] || slide_go)
                    state_next = S_CLAMP;
                else
                    state_next = S_DONE;
            end
            S_CLAMP:
            begin
                // clamp touches position only, so the slide product can start here
                cmd.act     = status.mode[MODE_LIMIT] ? ACT_CLAMP : ACT_NONE;
                cmd.mul_sel = MUL_VX_RATIO;
                state_next  = slide_go ? S_SLIDE_X : S_DONE;
            end
            S_SLIDE_X:
            begin
                cmd.act     = ACT_SLIDE_X;
                cmd.mul_sel = MUL_VY_RATIO;
                state_next  = S_SLIDE_Y;
            end
            S_SLIDE_Y:
            begin
                cmd.act    = ACT_SLIDE_Y;
                state_next = S_SLIDE_CHK;
            end
            S_SLIDE_CHK:
            begin
                cmd.act    = ACT_SLIDE_CHK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/emi2d_dp.sv =====
// ----------------------------------------------------------------------------
// emi2d_dp
// Datapath: configuration registers, entity state, one shared registered
// multiplier and the saturating update for each step.
// ----------------------------------------------------------------------------
module emi2d_dp
    import emi2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic [STEP_W-1:0]       in_step_time,
    input  logic signed [VAL_W-1:0] in_arg_x,
    input  logic signed [VAL_W-1:0] in_arg_y,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    output logic signed [VAL_W-1:0] out_pos_x,
    output logic signed [VAL_W-1:0] out_pos_y,
    output logic signed [VAL_W-1:0] out_vel_x,
    output logic signed [VAL_W-1:0] out_vel_y
);

    localparam int SHF_W = PROD_W - FRAC_BITS;
    localparam int SHR_W = PROD_W - RATIO_BITS;

    // configuration
    logic signed [VAL_W-1:0] gravity_rate_reg;
    logic [LIMIT_W-1:0]      fall_limit_reg;
    logic [RATIO_W-1:0]      slide_ratio_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic signed [VAL_W-1:0] bound_left_reg, bound_right_reg;
    logic signed [VAL_W-1:0] bound_bottom_reg, bound_top_reg;

    // entity state
    logic signed [VAL_W-1:0] pos_x_reg, pos_x_next;
    logic signed [VAL_W-1:0] pos_y_reg, pos_y_next;
    logic signed [VAL_W-1:0] vel_x_reg, vel_x_next;
    logic signed [VAL_W-1:0] vel_y_reg, vel_y_next;
    logic signed [VAL_W-1:0] fall_reg, fall_next;

    // item operands
    logic [STEP_W-1:0]       step_reg;
    logic signed [VAL_W-1:0] arg_x_reg, arg_y_reg;

    // multiplier
    logic signed [VAL_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SHF_W-1:0]   sh_frac;
    logic signed [SHR_W-1:0]   sh_ratio;

    // step terms
    logic signed [VAL_W-1:0] limit_s;
    logic signed [VAL_W-1:0] fall_sum;
    logic signed [SAT_W-1:0] dx, dy;
    logic signed [VAL_W-1:0] cx_lo, cx, cy_lo, cy;
    logic [VAL_W:0]          abs_x, abs_y;
    logic [VAL_W+1:0]        abs_sum;

    // output word
    logic signed [VAL_W-1:0] out_pos_x_reg, out_pos_y_reg;
    logic signed [VAL_W-1:0] out_vel_x_reg, out_vel_y_reg;

    assign status.mode     = mode_reg;
    assign status.vel_zero = (vel_x_reg == '0) && (vel_y_reg == '0);

    assign out_pos_x = out_pos_x_reg;
    assign out_pos_y = out_pos_y_reg;
    assign out_vel_x = out_vel_x_reg;
    assign out_vel_y = out_vel_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_rate_reg <= '0;
            fall_limit_reg   <= '0;
            slide_ratio_reg  <= RATIO_W'(1 << RATIO_BITS);
            mode_reg         <= '0;
            bound_left_reg   <= '0;
            bound_right_reg  <= '0;
            bound_bottom_reg <= '0;
            bound_top_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_GRAVITY_RATE: gravity_rate_reg <= cfg_data;
                REG_FALL_LIMIT:   fall_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_SLIDE_RATIO:  slide_ratio_reg  <= cfg_data[RATIO_W-1:0];
                REG_MODE_FLAGS:   mode_reg         <= cfg_data[MODE_W-1:0];
                REG_BOUND_LEFT:   bound_left_reg   <= cfg_data;
                REG_BOUND_RIGHT:  bound_right_reg  <= cfg_data;
                REG_BOUND_BOTTOM: bound_bottom_reg <= cfg_data;
                REG_BOUND_TOP:    bound_top_reg    <= cfg_data;
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_GRAV:
            begin
                mul_a = gravity_rate_reg;
                mul_b = {1'b0, step_reg};
            end
            MUL_VX_TS:
            begin
                mul_a = vel_x_reg;
                mul_b = {1'b0, step_reg};
            end
            MUL_VY_TS:
            begin
                mul_a = vel_y_reg;
                mul_b = {1'b0, step_reg};
            end
            MUL_VX_RATIO:
            begin
                mul_a = vel_x_reg;
                mul_b = MUL_B_W'({1'b0, slide_ratio_reg});
            end
            MUL_VY_RATIO:
            begin
                mul_a = vel_y_reg;
                mul_b = MUL_B_W'({1'b0, slide_ratio_reg});
            end
            default:
            begin
                mul_a = gravity_rate_reg;
                mul_b = {1'b0, step_reg};
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    // arithmetic shift right = floor toward minus infinity
    assign sh_frac   = prod_reg[PROD_W-1:FRAC_BITS];
    assign sh_ratio  = prod_reg[PROD_W-1:RATIO_BITS];

    assign limit_s  = {1'b0, fall_limit_reg};
    assign fall_sum = sat32(SAT_W'(fall_reg) + SAT_W'(sh_frac));

    assign dx = SAT_W'(arg_x_reg) - SAT_W'(pos_x_reg);
    assign dy = SAT_W'(arg_y_reg) - SAT_W'(pos_y_reg);

    // left then right, so crossed bounds end at right (top for y)
    assign cx_lo = (pos_x_reg < bound_left_reg) ? bound_left_reg : pos_x_reg;
    assign cx    = (cx_lo > bound_right_reg) ? bound_right_reg : cx_lo;
    assign cy_lo = (pos_y_reg < bound_bottom_reg) ? bound_bottom_reg : pos_y_reg;
    assign cy    = (cy_lo > bound_top_reg) ? bound_top_reg : cy_lo;

    assign abs_x   = vel_x_reg[VAL_W-1] ? ((VAL_W+1)'(0) - {vel_x_reg[VAL_W-1], vel_x_reg})
                                        : {1'b0, vel_x_reg};
    assign abs_y   = vel_y_reg[VAL_W-1] ? ((VAL_W+1)'(0) - {vel_y_reg[VAL_W-1], vel_y_reg})
                                        : {1'b0, vel_y_reg};
    assign abs_sum = {1'b0, abs_x} + {1'b0, abs_y};

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        vel_x_next = vel_x_reg;
        vel_y_next = vel_y_reg;
        fall_next  = fall_reg;
        case (cmd.act)
            ACT_NONE:
            begin
                fall_next = fall_reg;
            end
            ACT_LOAD_POS:
            begin
                pos_x_next = arg_x_reg;
                pos_y_next = arg_y_reg;
            end
            ACT_LOAD_VEL:
            begin
                vel_x_next = arg_x_reg;
                vel_y_next = arg_y_reg;
                fall_next  = '0;
            end
            ACT_GRAV:
            begin
                if (fall_reg < 0)
                begin
                    vel_y_next = sat32(SAT_W'(vel_y_reg) - SAT_W'(sh_frac));
                end
                else if ((fall_reg < limit_s) || (fall_limit_reg == '0))
                begin
                    fall_next  = fall_sum;
                    vel_y_next = sat32(SAT_W'(vel_y_reg) - SAT_W'(fall_sum));
                end
                else
                begin
                    fall_next  = limit_s;
                    vel_y_next = sat32(SAT_W'(vel_y_reg) - SAT_W'(limit_s));
                end
            end
            ACT_FOLLOW:
            begin
                // gap * 5 as gap * 4 + gap
                vel_x_next = sat32((dx <<< 2) + dx);
                vel_y_next = sat32((dy <<< 2) + dy);
            end
            ACT_INT_X:
            begin
                pos_x_next = sat32(SAT_W'(pos_x_reg) + SAT_W'(sh_frac));
            end
            ACT_INT_Y:
            begin
                pos_y_next = sat32(SAT_W'(pos_y_reg) + SAT_W'(sh_frac));
            end
            ACT_CLAMP:
            begin
                pos_x_next = cx;
                pos_y_next = cy;
            end
            ACT_SLIDE_X:
            begin
                vel_x_next = sat32(SAT_W'(sh_ratio));
            end
            ACT_SLIDE_Y:
            begin
                vel_y_next = sat32(SAT_W'(sh_ratio));
            end
            ACT_SLIDE_CHK:
            begin
                if (abs_sum < (VAL_W+2)'(SLIDE_THRESH))
                begin
                    vel_x_next = '0;
                    vel_y_next = '0;
                end
            end
            default:
            begin
                fall_next = fall_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            fall_reg  <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            vel_x_reg <= vel_x_next;
            vel_y_reg <= vel_y_next;
            fall_reg  <= fall_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.capture)
        begin
            step_reg  <= in_step_time;
            arg_x_reg <= in_arg_x;
            arg_y_reg <= in_arg_y;
        end
        if (cmd.load_out)
        begin
            out_pos_x_reg <= pos_x_reg;
            out_pos_y_reg <= pos_y_reg;
            out_vel_x_reg <= vel_x_reg;
            out_vel_y_reg <= vel_y_reg;
        end
    end

endmodule

// ===== rtl/entity_motion_integrator_2d.sv =====
// ----------------------------------------------------------------------------
// entity_motion_integrator_2d
// 2D entity motion integrator: gravity, follow, integration, clamping and
// sliding decay on Q16.16 state, with load items for position and velocity.
// ----------------------------------------------------------------------------
// Items are taken one at a time: s_tready is high only while idle, so a new item
//   is accepted only after the last result word is loaded, which waits on m_tready.
// A tick runs its products through the single shared 32x18 multiplier, which does
//   up to five dependent products.
// Reset: state and config registers clear (slide_ratio to one); config always ready.
module entity_motion_integrator_2d
    import emi2d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // step_time, arg_x, arg_y
    input  logic [OPC_W-1:0]       s_tuser,   // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [VAL_W-1:0]       cfg_data
);

    dp_cmd_t                 cmd;
    dp_status_t              status;
    logic signed [VAL_W-1:0] pos_x, pos_y, vel_x, vel_y;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {vel_y, vel_x, pos_y, pos_x};

    emi2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    emi2d_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_step_time (s_tdata[STEP_W-1:0]),
        .in_arg_x     (s_tdata[STEP_W+VAL_W-1:STEP_W]),
        .in_arg_y     (s_tdata[STEP_W+2*VAL_W-1:STEP_W+VAL_W]),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_pos_x    (pos_x),
        .out_pos_y    (pos_y),
        .out_vel_x    (vel_x),
        .out_vel_y    (vel_y)
    );

endmodule
